>>> hdl/indexed_deque_list_assert.svh
// Assertion macros used by the checker file, idl_checker.sv.
`ifndef INDEXED_DEQUE_LIST_ASSERT_SVH
`define INDEXED_DEQUE_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IDL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IDL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/idl_pkg.sv
package idl_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths
  localparam int OP_W  = 4;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;

  // Slave tdata: opcode, value, position
  localparam int S_TDATA_W = 48;
  localparam int S_VAL_LSB = OP_W;
  localparam int S_POS_LSB = OP_W + VAL_W;

  // Master tdata: ok, element_value, count, front_value, back_value
  localparam int M_EV_LSB    = 1;
  localparam int M_CNT_LSB   = M_EV_LSB + VAL_W;
  localparam int M_FRONT_LSB = M_CNT_LSB + CNT_W;
  localparam int M_BACK_LSB  = M_FRONT_LSB + VAL_W;
  localparam int M_USED_W    = M_BACK_LSB + VAL_W;
  localparam int M_TDATA_W   = 104;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_HEAD = 4'd0,
    OP_POP_HEAD  = 4'd1,
    OP_PUSH_TAIL = 4'd2,
    OP_POP_TAIL  = 4'd3,
    OP_INSERT    = 4'd4,
    OP_ERASE     = 4'd5,
    OP_CLEAR     = 4'd6,
    OP_CONTAIN   = 4'd7,
    OP_TRAVERSE  = 4'd8
  } op_e;

endpackage

>>> hdl/idl_ram.sv
module idl_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/indexed_deque_list.sv
// Ordered list of up to CAPACITY words used as a deque with indexed insert
// and erase. Items enter on the s_axis channel (opcode, value, position);
// results leave on m_axis with tuser = is_element and tlast on the final
// result of each item. Every result carries ok, count, front and back.
// One item at a time: s_axis_tready is high only while the sequencer is
// idle. All storage sits in a single-port-write, registered-read RAM, and
// one read plus one write per cycle set the timing. Work done per item,
// after which front and back are read and the result is loaded:
//   tail push or pop, clear, erase at zero, failed ops: no other work
//   head push, insert:  shift elements from position upward, top first
//   head pop, erase:    shift elements above position down, bottom first,
//                       position 1-based and 1 for a head pop
//   contain:            read from the head until a match or the end
//   traverse:           then one result per element, head to tail
// The next item is taken the cycle after a result is loaded. The output
// register holds a finished result while m_axis_tready is low; a new item
// is taken meanwhile, and a traverse waits for each slot. Reset empties
// the list; no clearing pass is needed since only entries below the count
// are ever used.
module indexed_deque_list
  import idl_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [3:0] opcode, [35:4] value, [40:36] position
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] ok, [32:1] element_value, [37:33] count, [69:38] front_value,
  // [101:70] back_value
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] is_element
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SHUP  = 10'b0000000010,
    ST_SHDN  = 10'b0000000100,
    ST_SCAN  = 10'b0000001000,
    ST_FRONT = 10'b0000010000,
    ST_BACK  = 10'b0000100000,
    ST_FIN   = 10'b0001000000,
    ST_OUT   = 10'b0010000000,
    ST_TRD   = 10'b0100000000,
    ST_TEM   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] ins_q, ins_d;
  logic [CW-1:0] wa_q, wa_d;
  logic          pend_q, pend_d;
  logic          ok_q, ok_d;
  op_e           op_q, op_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;

  logic             mval_q, mval_d;
  logic             mok_q, mok_d;
  logic             melem_q, melem_d;
  logic [VAL_W-1:0] mev_q, mev_d;
  logic             mlast_q, mlast_d;
  logic [CNT_W-1:0] mcnt_q, mcnt_d;
  logic [VAL_W-1:0] mfront_q, mfront_d;
  logic [VAL_W-1:0] mback_q, mback_d;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  op_e                   in_op;
  logic [DATA_WIDTH-1:0] in_val;
  logic [POS_W-1:0]      in_pos;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         cnt_x;
  logic [CW-1:0]         idx_m1;
  logic [CW-1:0]         cnt_m1;
  logic                  not_full;
  logic                  empty;
  logic                  out_free;

  assign in_op    = op_e'(s_axis_tdata[OP_W-1:0]);
  assign in_val   = DATA_WIDTH'(s_axis_tdata[S_VAL_LSB +: VAL_W]);
  assign in_pos   = s_axis_tdata[S_POS_LSB +: POS_W];
  assign pos_x    = XW'(in_pos);
  assign cnt_x    = XW'(cnt_q);
  assign idx_m1   = idx_q - 1'b1;
  assign cnt_m1   = cnt_q - 1'b1;
  assign not_full = (cnt_q < CW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign out_free = !mval_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    ins_d    = ins_q;
    wa_d     = wa_q;
    pend_d   = pend_q;
    ok_d     = ok_q;
    op_d     = op_q;
    val_d    = val_q;
    front_d  = front_q;
    back_d   = back_q;
    mval_d   = mval_q && !m_axis_tready;
    mok_d    = mok_q;
    melem_d  = melem_q;
    mev_d    = mev_q;
    mlast_d  = mlast_q;
    mcnt_d   = mcnt_q;
    mfront_d = mfront_q;
    mback_d  = mback_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = val_q;
    raddr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = in_op;
          val_d   = in_val;
          ok_d    = 1'b0;
          pend_d  = 1'b0;
          state_d = ST_FRONT;
          unique case (in_op)
            OP_PUSH_HEAD: begin
              if (not_full) begin
                ok_d    = 1'b1;
                ins_d   = '0;
                idx_d   = cnt_q;
                state_d = ST_SHUP;
              end
            end
            OP_INSERT: begin
              if (not_full && ((pos_x < cnt_x) || (empty && in_pos == '0))) begin
                ok_d    = 1'b1;
                ins_d   = CW'(in_pos);
                idx_d   = cnt_q;
                state_d = ST_SHUP;
              end
            end
            OP_POP_HEAD: begin
              if (!empty) begin
                ok_d    = 1'b1;
                idx_d   = CW'(1);
                state_d = ST_SHDN;
              end
            end
            OP_ERASE: begin
              if (in_pos == '0) begin
                ok_d = 1'b1;
              end else if (pos_x <= cnt_x) begin
                ok_d    = 1'b1;
                idx_d   = CW'(in_pos);
                state_d = ST_SHDN;
              end
            end
            OP_PUSH_TAIL: begin
              if (not_full) begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                wdata = in_val;
                cnt_d = cnt_q + 1'b1;
                ok_d  = 1'b1;
              end
            end
            OP_POP_TAIL: begin
              if (!empty) begin
                cnt_d = cnt_m1;
                ok_d  = 1'b1;
              end
            end
            OP_CLEAR: begin
              ok_d  = !empty;
              cnt_d = '0;
            end
            OP_CONTAIN: begin
              idx_d   = '0;
              state_d = ST_SCAN;
            end
            OP_TRAVERSE: begin
              ok_d = !empty;
            end
            default: begin
            end
          endcase
        end
      end

      // Move elements up one slot, top first, then drop the new word in.
      ST_SHUP: begin
        raddr = idx_m1[AW-1:0];
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q[AW-1:0];
          wdata = rdata;
        end
        if (idx_q > ins_q) begin
          pend_d = 1'b1;
          wa_d   = idx_q;
          idx_d  = idx_m1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            we      = 1'b1;
            waddr   = ins_q[AW-1:0];
            wdata   = val_q;
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_FRONT;
          end
        end
      end

      // Move elements above the erased slot down one, bottom first.
      ST_SHDN: begin
        raddr = idx_q[AW-1:0];
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q[AW-1:0];
          wdata = rdata;
        end
        if (idx_q < cnt_q) begin
          pend_d = 1'b1;
          wa_d   = idx_m1;
          idx_d  = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d   = cnt_m1;
            state_d = ST_FRONT;
          end
        end
      end

      ST_SCAN: begin
        raddr = idx_q[AW-1:0];
        if (pend_q && rdata == val_q) begin
          ok_d    = 1'b1;
          pend_d  = 1'b0;
          state_d = ST_FRONT;
        end else if (idx_q < cnt_q) begin
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_FRONT;
          end
        end
      end

      ST_FRONT: begin
        raddr   = '0;
        state_d = ST_BACK;
      end

      ST_BACK: begin
        raddr   = empty ? '0 : cnt_m1[AW-1:0];
        front_d = empty ? '0 : rdata;
        state_d = ST_FIN;
      end

      ST_FIN: begin
        back_d = empty ? '0 : rdata;
        if (op_q == OP_TRAVERSE && !empty) begin
          idx_d   = '0;
          state_d = ST_TRD;
        end else begin
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          mval_d   = 1'b1;
          mok_d    = ok_q;
          melem_d  = 1'b0;
          mev_d    = '0;
          mlast_d  = 1'b1;
          mcnt_d   = CNT_W'(cnt_q);
          mfront_d = VAL_W'(front_q);
          mback_d  = VAL_W'(back_q);
          state_d  = ST_IDLE;
        end
      end

      ST_TRD: begin
        raddr   = idx_q[AW-1:0];
        state_d = ST_TEM;
      end

      // Hold the read address so the data stays put while the output stalls.
      ST_TEM: begin
        raddr = idx_q[AW-1:0];
        if (out_free) begin
          mval_d   = 1'b1;
          mok_d    = 1'b1;
          melem_d  = 1'b1;
          mev_d    = VAL_W'(rdata);
          mlast_d  = (idx_q == cnt_m1);
          mcnt_d   = CNT_W'(cnt_q);
          mfront_d = VAL_W'(front_q);
          mback_d  = VAL_W'(back_q);
          if (idx_q == cnt_m1) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_TRD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      mval_q  <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ins_q    <= ins_d;
    wa_q     <= wa_d;
    ok_q     <= ok_d;
    op_q     <= op_d;
    val_q    <= val_d;
    front_q  <= front_d;
    back_q   <= back_d;
    mok_q    <= mok_d;
    melem_q  <= melem_d;
    mev_q    <= mev_d;
    mlast_q  <= mlast_d;
    mcnt_q   <= mcnt_d;
    mfront_q <= mfront_d;
    mback_q  <= mback_d;
  end

  idl_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}},
                          mback_q, mfront_q, mcnt_q, mev_q, mok_q};
  assign m_axis_tuser  = melem_q;
  assign m_axis_tlast  = mlast_q;

endmodule

>>> hdl/idl_checker.sv
`include "indexed_deque_list_assert.svh"

module idl_checker
  import idl_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 m_axis_tlast
);

  logic             out_stall;
  logic             out_ok;
  logic [VAL_W-1:0] out_ev;
  logic [CNT_W-1:0] out_cnt;
  logic [VAL_W-1:0] out_front;
  logic [VAL_W-1:0] out_back;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_ok    = m_axis_tdata[0];
  assign out_ev    = m_axis_tdata[M_EV_LSB +: VAL_W];
  assign out_cnt   = m_axis_tdata[M_CNT_LSB +: CNT_W];
  assign out_front = m_axis_tdata[M_FRONT_LSB +: VAL_W];
  assign out_back  = m_axis_tdata[M_BACK_LSB +: VAL_W];

  `IDL_ASSERT_NXT(a_stall_hold, out_stall,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "result changed while stalled")

  `IDL_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "command taken while a previous one is still running")

  `IDL_ASSERT_IMP(a_element_ok, m_axis_tvalid && m_axis_tuser, out_ok,
    "traversed element without ok")

  `IDL_ASSERT_IMP(a_single_shape, m_axis_tvalid && !m_axis_tuser,
    m_axis_tlast && out_ev == '0, "non-element result not last or carries a value")

  `IDL_ASSERT_IMP(a_empty_ends, m_axis_tvalid && out_cnt == '0,
    out_front == '0 && out_back == '0 && !m_axis_tuser, "empty list reports data")

endmodule

bind indexed_deque_list idl_checker u_idl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
